/* src/pfa_pkg.sv */
package pfa_pkg;

  localparam int ADDR_W   = 32;
  localparam int PG_SHIFT = 12;
  localparam int IDX_W    = ADDR_W - PG_SHIFT;
  localparam int PTR_W    = IDX_W + 1;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W    = 8;
  localparam int ST_W     = 3;

  localparam logic [CFG_W-1:0] CNT_MAX = {CFG_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd1;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_OOM        = 3'd1;
  localparam logic [ST_W-1:0] ST_MISALIGNED = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE      = 3'd3;
  localparam logic [ST_W-1:0] ST_UNREF      = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] page_addr;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_addr;
    logic [ST_W-1:0]   status;
    logic [CFG_W-1:0]  free_count;
  } out_t;

  typedef struct packed {
    logic clr_step;
    logic load_req;
    logic scan_step;
    logic take_alloc;
    logic fail_oom;
    logic rel_read;
    logic rel_eval;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_release;
    logic scan_hit;
    logic scan_empty;
  } sts_t;

endpackage

/* src/pfa_ctrl.sv */
module pfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  pfa_pkg::sts_t  sts,
  output logic           busy,
  output pfa_pkg::cmd_t  cmd
);
  import pfa_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_REL_RD = 3'd3;
  localparam logic [2:0] S_REL_EV = 3'd4;

  logic [2:0] state_r, state_nxt;

  // request type comes straight from the input word in idle
  function automatic logic in_is_release(input logic go, input sts_t s);
    in_is_release = go & s.is_release;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_nxt    = (in_is_release(start, sts)) ? S_REL_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) begin
          cmd.take_alloc = 1'b1;
          cmd.finish     = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.scan_empty) begin
          cmd.fail_oom = 1'b1;
          cmd.finish   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_REL_RD: begin
        cmd.rel_read = 1'b1;
        state_nxt    = S_REL_EV;
      end
      S_REL_EV: begin
        cmd.rel_eval = 1'b1;
        cmd.finish   = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* src/pfa_datapath.sv */
module pfa_datapath #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]       cfg_data,
  input  pfa_pkg::in_t                    in_word,
  input  pfa_pkg::cmd_t                   cmd,
  output pfa_pkg::sts_t                   sts,
  output logic                            out_valid,
  output pfa_pkg::out_t                   out_word
);
  import pfa_pkg::*;

  localparam int AW = $clog2(MAX_PAGES);
  localparam logic [PTR_W-1:0] MAX_EFF  = PTR_W'(MAX_PAGES);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(MAX_PAGES - 1);

  logic [CNT_W-1:0] ref_cnt_mem [MAX_PAGES];

  logic [CFG_W-1:0]  first_r, first_nxt;
  logic [CFG_W-1:0]  total_r, total_nxt;
  logic [CFG_W-1:0]  free_r, free_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [PTR_W-1:0]  chk_r, chk_nxt;
  logic              inflight_r, inflight_nxt;
  in_t               req_r;
  logic [CNT_W-1:0]  rd_data_r;
  logic              out_valid_r;
  out_t              out_word_r, out_word_nxt;

  logic [PTR_W-1:0]  eff_total, first_ext, rel_idx;
  logic [PTR_W-1:0]  nxt_total_ext, nxt_eff, nxt_first_ext;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [CNT_W-1:0]  wr_data;
  logic              wr_en;
  logic              misaligned, range_bad, unref, rel_ok, ptr_in_range;
  logic [ST_W-1:0]   rel_status;
  logic              cfg_hit;

  function automatic logic [PTR_W-1:0] clip_total(input logic [PTR_W-1:0] t);
    clip_total = (t > MAX_EFF) ? MAX_EFF : t;
  endfunction

  assign first_ext    = PTR_W'(first_r);
  assign eff_total    = clip_total(PTR_W'(total_r));
  assign ptr_in_range = (ptr_r < eff_total);
  assign rel_idx      = {1'b0, req_r.page_addr[ADDR_W-1:PG_SHIFT]};

  // release checks, in priority order
  assign misaligned = |req_r.page_addr[PG_SHIFT-1:0];
  assign range_bad  = (rel_idx < first_ext) || (rel_idx >= eff_total);
  assign unref      = (rd_data_r == '0);
  assign rel_ok     = !misaligned && !range_bad && !unref;

  always_comb begin
    if (misaligned) begin
      rel_status = ST_MISALIGNED;
    end else if (range_bad) begin
      rel_status = ST_RANGE;
    end else if (unref) begin
      rel_status = ST_UNREF;
    end else begin
      rel_status = ST_OK;
    end
  end

  // config: either register write reloads the free counter
  assign cfg_hit = cfg_we && ((cfg_index == CFG_FIRST) || (cfg_index == CFG_TOTAL));

  always_comb begin
    first_nxt = first_r;
    total_nxt = total_r;
    if (cfg_we && (cfg_index == CFG_FIRST)) begin
      first_nxt = cfg_data;
    end
    if (cfg_we && (cfg_index == CFG_TOTAL)) begin
      total_nxt = cfg_data;
    end
  end

  assign nxt_total_ext = PTR_W'(total_nxt);
  assign nxt_eff       = clip_total(nxt_total_ext);
  assign nxt_first_ext = PTR_W'(first_nxt);

  always_comb begin
    free_nxt = free_r;
    if (cfg_hit) begin
      free_nxt = (nxt_first_ext >= nxt_eff) ? '0 : CFG_W'(nxt_eff - nxt_first_ext);
    end else if (cmd.take_alloc) begin
      if (free_r != '0) begin
        free_nxt = free_r - 1'b1;
      end
    end else if (cmd.rel_eval && rel_ok && (rd_data_r == CNT_W'(1))) begin
      if (free_r != CNT_MAX) begin
        free_nxt = free_r + 1'b1;
      end
    end
  end

  // scan pointer: one read issued per cycle, its data checked in the cycle after
  always_comb begin
    ptr_nxt      = ptr_r;
    chk_nxt      = chk_r;
    inflight_nxt = inflight_r;
    if (cmd.clr_step) begin
      ptr_nxt = ptr_r + 1'b1;
    end else if (cmd.load_req) begin
      ptr_nxt      = first_ext;
      inflight_nxt = 1'b0;
    end else if (cmd.scan_step) begin
      chk_nxt      = ptr_r;
      inflight_nxt = ptr_in_range;
      if (ptr_in_range) begin
        ptr_nxt = ptr_r + 1'b1;
      end
    end
  end

  assign rd_addr = cmd.rel_read ? rel_idx[AW-1:0] : ptr_r[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[AW-1:0];
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd.take_alloc) begin
      wr_en   = 1'b1;
      wr_addr = chk_r[AW-1:0];
      wr_data = CNT_W'(1);
    end else if (cmd.rel_eval && rel_ok) begin
      wr_en   = 1'b1;
      wr_addr = rel_idx[AW-1:0];
      wr_data = rd_data_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ref_cnt_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= ref_cnt_mem[rd_addr];
  end

  always_comb begin
    out_word_nxt            = '0;
    out_word_nxt.free_count = free_nxt;
    if (cmd.take_alloc) begin
      out_word_nxt.alloc_addr = {chk_r[IDX_W-1:0], {PG_SHIFT{1'b0}}};
      out_word_nxt.status     = ST_OK;
    end else if (cmd.fail_oom) begin
      out_word_nxt.status = ST_OOM;
    end else begin
      out_word_nxt.status = rel_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      total_r     <= CFG_W'(4096);
      free_r      <= '0;
      ptr_r       <= '0;
      inflight_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      first_r     <= first_nxt;
      total_r     <= total_nxt;
      free_r      <= free_nxt;
      ptr_r       <= ptr_nxt;
      inflight_r  <= inflight_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    chk_r <= chk_nxt;
    if (cmd.load_req) begin
      req_r <= in_word;
    end
    if (cmd.finish) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign sts.clr_last   = (ptr_r == LAST_IDX);
  assign sts.is_release = (in_word.req_type == REQ_RELEASE);
  assign sts.scan_hit   = inflight_r && (rd_data_r == '0);
  assign sts.scan_empty = !inflight_r && !ptr_in_range;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* src/page_frame_allocator.sv */
// channel | ports                                     | flow
// --------+-------------------------------------------+-----------------------------------
// in      | start, busy, in_word                      | word taken when start && !busy
// out     | out_valid, out_word                       | one-cycle strobe, no back-pressure
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | write when cfg_valid && cfg_ready
//
// Release: after accept the count is read (REL_RD), then checked and updated (REL_EV).
// Allocate: first-fit scan, one count-store read per cycle, pipelined one deep, over pages
//   first_usable_page up to clipped page_total; the first page with a zero count is taken,
//   and out of memory is reported once that span is used up (or is empty).
// After reset every count-store entry is cleared, one entry a cycle, with busy high.
// Config writes are taken at any time (cfg_ready tied high); results cannot be stalled,
//   and the next word is accepted in the cycle the previous result is strobed.
module page_frame_allocator #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  pfa_pkg::in_t                   in_word,
  output logic                           out_valid,
  output pfa_pkg::out_t                  out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]      cfg_data
);
  import pfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  pfa_datapath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status != ST_OK)) |-> (out_word.alloc_addr == '0))
    else $error("failed request returned an address");

  a_ok_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.alloc_addr[PG_SHIFT-1:0] == '0))
    else $error("allocated address not page aligned");

endmodule
